/* hw/rtl/sba_pkg.sv */
// Shared constants, types and helper functions for the segregated buffer allocator.
// Used by the descriptor memory and by the allocator top level. No dependencies.
`timescale 1ns / 1ps

package sba_pkg;

    // Pool geometry
    localparam int NUM_REGIONS  = 4;
    localparam int REGION_BYTES = 32768;
    localparam int SPLIT_LEVELS = 7;
    localparam int HEADER_BYTES = 64;

    localparam int MIN_BLOCK    = REGION_BYTES >> SPLIT_LEVELS;
    localparam int NSLOTS       = NUM_REGIONS << SPLIT_LEVELS;
    localparam int NCLS         = SPLIT_LEVELS + 1;

    // Widths
    localparam int ADDR_W       = $clog2(NUM_REGIONS * REGION_BYTES);
    localparam int LEN_W        = $clog2(REGION_BYTES + 1);
    localparam int SLOT_W       = $clog2(NSLOTS);
    localparam int LINK_W       = SLOT_W + 1;
    localparam int CLS_IDX_W    = $clog2(NCLS);
    localparam int CLS_W        = CLS_IDX_W + 1;
    localparam int REG_W        = $clog2(NUM_REGIONS);
    localparam int POOL_W       = $clog2(NUM_REGIONS * REGION_BYTES + 1);
    localparam int CNT_W        = 16;
    localparam int FAIL_W       = 32;
    localparam int SIZE_W       = 17;
    localparam int RSV_W        = 16;
    localparam int OP_W         = 3;
    localparam int ST_W         = 3;
    localparam int MIN_SHIFT    = $clog2(MIN_BLOCK);
    localparam int REGION_SHIFT = $clog2(REGION_BYTES);

    localparam logic [LINK_W-1:0] LINK_NIL = '1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OP_W-1:0] OP_REF   = 3'd1;
    localparam logic [OP_W-1:0] OP_DROP  = 3'd2;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd4;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK           = 3'd0;
    localparam logic [ST_W-1:0] ST_TOO_LARGE    = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY_ATOMIC = 3'd2;
    localparam logic [ST_W-1:0] ST_NO_REGION    = 3'd3;
    localparam logic [ST_W-1:0] ST_CORRUPT      = 3'd4;

    // One descriptor per slot
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] start;
        logic [CNT_W-1:0]  use_cnt;
        logic [LINK_W-1:0] pprev;
        logic [LINK_W-1:0] pnext;
        logic [LINK_W-1:0] fprev;
        logic [LINK_W-1:0] fnext;
    } t_desc;

    typedef struct packed {
        logic len;
        logic start;
        logic use_cnt;
        logic pprev;
        logic pnext;
        logic fprev;
        logic fnext;
    } t_wmask;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_wmask            mask;
        t_desc             data;
    } t_mem_wr;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } t_mem_rd;

    // Smallest class whose threshold the length meets; NCLS when none fits
    function automatic logic [CLS_W-1:0] class_of(input logic [LEN_W-1:0] len);
        logic [CLS_W-1:0] c;
        c = CLS_W'(NCLS);
        for (int i = NCLS - 1; i >= 0; i--) begin
            if (32'(len) >= (REGION_BYTES >> i)) c = CLS_W'(i);
        end
        if (32'(len) > REGION_BYTES) c = CLS_W'(NCLS);
        return c;
    endfunction

    // Largest class whose threshold still holds the request
    function automatic logic [CLS_IDX_W-1:0] fit_class(input logic [SIZE_W-1:0] size);
        logic [CLS_IDX_W-1:0] c;
        c = '0;
        for (int i = 0; i < NCLS; i++) begin
            if (32'(size) <= (REGION_BYTES >> i)) c = CLS_IDX_W'(i);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/sba_desc_mem.sv */
// Block descriptor memory: one entry per slot, per-field write enables.
// Registered synchronous read. Depends on sba_pkg.
`timescale 1ns / 1ps

module sba_desc_mem import sba_pkg::*; (
    input  logic    i_clk,
    input  t_mem_wr i_wr,
    input  t_mem_rd i_rd,
    output t_desc   o_rd_data
);

    t_desc r_mem [NSLOTS];
    t_desc r_rd_data;

    // Write enabled fields only
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            if (i_wr.mask.len)     r_mem[i_wr.addr].len     <= i_wr.data.len;
            if (i_wr.mask.start)   r_mem[i_wr.addr].start   <= i_wr.data.start;
            if (i_wr.mask.use_cnt) r_mem[i_wr.addr].use_cnt <= i_wr.data.use_cnt;
            if (i_wr.mask.pprev)   r_mem[i_wr.addr].pprev   <= i_wr.data.pprev;
            if (i_wr.mask.pnext)   r_mem[i_wr.addr].pnext   <= i_wr.data.pnext;
            if (i_wr.mask.fprev)   r_mem[i_wr.addr].fprev   <= i_wr.data.fprev;
            if (i_wr.mask.fnext)   r_mem[i_wr.addr].fnext   <= i_wr.data.fnext;
        end
    end

    // Register read data
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/segregated_buffer_allocator_top.sv */
// Segregated free-list buffer allocator: request sequencer and pool state.
// Depends on sba_pkg and sba_desc_mem.
`timescale 1ns / 1ps

// Usage:
//   Requests come in on the command port: a transfer happens at a rising edge with
//   start high and busy low. The fields i_op, i_req_size, i_headroom, i_atomic and
//   i_handle are sampled at that edge. Every request gives exactly one result,
//   shown for one cycle with o_valid high; the receiver cannot stall it.
//   Sequencing: a request walks a sequencer over the descriptor memory, at most one
//   read or one write per cycle, until the result shows. A deferred region add
//   runs in front of a request, a non-atomic alloc that finds no free block adds a
//   region first, and a tick unlinks and clears each region that it releases.
//   busy stays high for the whole request and drops in the cycle that shows the
//   result, so the next request can be taken in that same cycle.
//   Reset: after i_rst_n is released the block clears the 512-entry descriptor
//   memory, one entry a cycle, with busy high; region zero is then one free block
//   and the pool holds one region.
//   o_pool_bytes and o_failed_allocations always show the current counters.

module segregated_buffer_allocator_top import sba_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       i_op,
    input  logic [15:0]           i_req_size,
    input  logic [14:0]           i_headroom,
    input  logic                  i_atomic,
    input  logic [ADDR_W-1:0]     i_handle,
    output logic                  o_valid,
    output logic [ST_W-1:0]       o_status,
    output logic [ADDR_W-1:0]     o_block_addr,
    output logic [LEN_W-1:0]      o_block_len,
    output logic [ADDR_W-1:0]     o_data_addr,
    output logic [POOL_W-1:0]     o_pool_bytes,
    output logic [FAIL_W-1:0]     o_failed_allocations
);

    // Sequencer states
    localparam int SW = 5;
    localparam logic [SW-1:0] S_CLR      = 5'd0;
    localparam logic [SW-1:0] S_IDLE     = 5'd1;
    localparam logic [SW-1:0] S_ADD0     = 5'd2;
    localparam logic [SW-1:0] S_ADD1     = 5'd3;
    localparam logic [SW-1:0] S_DISP     = 5'd4;
    localparam logic [SW-1:0] S_AL_RETRY = 5'd5;
    localparam logic [SW-1:0] S_AL_RD    = 5'd6;
    localparam logic [SW-1:0] S_PL0      = 5'd7;
    localparam logic [SW-1:0] S_PL1      = 5'd8;
    localparam logic [SW-1:0] S_AL_SPLIT = 5'd9;
    localparam logic [SW-1:0] S_AL_T     = 5'd10;
    localparam logic [SW-1:0] S_AL_S     = 5'd11;
    localparam logic [SW-1:0] S_PS0      = 5'd12;
    localparam logic [SW-1:0] S_PS1      = 5'd13;
    localparam logic [SW-1:0] S_AL_OUT   = 5'd14;
    localparam logic [SW-1:0] S_H_RD     = 5'd15;
    localparam logic [SW-1:0] S_REL0     = 5'd16;
    localparam logic [SW-1:0] S_REL1     = 5'd17;
    localparam logic [SW-1:0] S_REL2     = 5'd18;
    localparam logic [SW-1:0] S_REL2A    = 5'd19;
    localparam logic [SW-1:0] S_REL2B    = 5'd20;
    localparam logic [SW-1:0] S_REL3     = 5'd21;
    localparam logic [SW-1:0] S_REL4     = 5'd22;
    localparam logic [SW-1:0] S_REL5     = 5'd23;
    localparam logic [SW-1:0] S_REL5B    = 5'd24;
    localparam logic [SW-1:0] S_REL5C    = 5'd25;
    localparam logic [SW-1:0] S_REL6     = 5'd26;
    localparam logic [SW-1:0] S_TK0      = 5'd27;
    localparam logic [SW-1:0] S_TK1      = 5'd28;
    localparam logic [SW-1:0] S_TK2      = 5'd29;
    localparam logic [SW-1:0] S_FIN      = 5'd30;

    // Control registers
    logic [SW-1:0]          r_state, n_state;
    logic [SW-1:0]          r_ret, n_ret;
    logic [SLOT_W-1:0]      r_clr, n_clr;
    logic                   r_valid, n_valid;
    logic [POOL_W-1:0]      r_pool, n_pool;
    logic [FAIL_W-1:0]      r_failed, n_failed;
    logic                   r_grow, n_grow;
    logic [NUM_REGIONS-1:0] r_region_active, n_region_active;
    logic [LINK_W-1:0]      r_head [NCLS];
    logic [LINK_W-1:0]      n_head [NCLS];

    // Request and working registers
    logic [OP_W-1:0]        r_op, n_op;
    logic [SIZE_W-1:0]      r_size, n_size;
    logic [RSV_W-1:0]       r_rsv, n_rsv;
    logic                   r_atomic, n_atomic;
    logic [ADDR_W-1:0]      r_handle, n_handle;
    logic [ST_W-1:0]        r_status, n_status;
    logic [ADDR_W-1:0]      r_baddr, n_baddr;
    logic [LEN_W-1:0]       r_blen, n_blen;
    logic [ADDR_W-1:0]      r_daddr, n_daddr;
    logic [SLOT_W-1:0]      r_cur, n_cur;
    logic [LEN_W-1:0]       r_cur_len, n_cur_len;
    logic [ADDR_W-1:0]      r_cur_start, n_cur_start;
    logic [LINK_W-1:0]      r_cur_pnext, n_cur_pnext;
    logic [LINK_W-1:0]      r_cur_pprev, n_cur_pprev;
    logic [SLOT_W-1:0]      r_nb, n_nb;
    logic [LEN_W-1:0]       r_nb_len, n_nb_len;
    logic [LINK_W-1:0]      r_nb_pnext, n_nb_pnext;
    logic [LEN_W-1:0]       r_pl_len, n_pl_len;
    logic [LINK_W-1:0]      r_pl_fprev, n_pl_fprev;
    logic [LINK_W-1:0]      r_pl_fnext, n_pl_fnext;
    logic [SLOT_W-1:0]      r_ps_slot, n_ps_slot;
    logic [CLS_IDX_W-1:0]   r_ps_cls, n_ps_cls;
    logic [LINK_W-1:0]      r_ps_head, n_ps_head;
    logic [SLOT_W-1:0]      r_tslot, n_tslot;
    logic [SLOT_W-1:0]      r_add_slot, n_add_slot;
    logic [LINK_W-1:0]      r_add_head, n_add_head;
    logic                   r_add_ok, n_add_ok;

    t_mem_wr w_wr;
    t_mem_rd w_rd;
    t_desc   w_rd_data;

    sba_desc_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_rd_data)
    );

    // Sequencer: at most one memory read or one write per state, never both, so a
    // read always sees every earlier write and no forwarding is needed.
    always_comb begin
        logic [SIZE_W-1:0]    sz;
        logic [CLS_W-1:0]     cls;
        logic [CLS_W-1:0]     rcls;
        logic [CLS_W-1:0]     ccls;
        logic [CLS_IDX_W-1:0] fidx;
        logic                 found;
        logic [CLS_IDX_W-1:0] sel;
        logic                 rfound;
        logic [REG_W-1:0]     rsel;
        logic [LEN_W-1:0]     rem;
        logic [ADDR_W-1:0]    split_addr;
        logic [CNT_W-1:0]     ucnt;
        logic [LINK_W-1:0]    hd;

        n_state         = r_state;
        n_ret           = r_ret;
        n_clr           = r_clr;
        n_valid         = 1'b0;
        n_pool          = r_pool;
        n_failed        = r_failed;
        n_grow          = r_grow;
        n_region_active = r_region_active;
        n_head          = r_head;
        n_op            = r_op;
        n_size          = r_size;
        n_rsv           = r_rsv;
        n_atomic        = r_atomic;
        n_handle        = r_handle;
        n_status        = r_status;
        n_baddr         = r_baddr;
        n_blen          = r_blen;
        n_daddr         = r_daddr;
        n_cur           = r_cur;
        n_cur_len       = r_cur_len;
        n_cur_start     = r_cur_start;
        n_cur_pnext     = r_cur_pnext;
        n_cur_pprev     = r_cur_pprev;
        n_nb            = r_nb;
        n_nb_len        = r_nb_len;
        n_nb_pnext      = r_nb_pnext;
        n_pl_len        = r_pl_len;
        n_pl_fprev      = r_pl_fprev;
        n_pl_fnext      = r_pl_fnext;
        n_ps_slot       = r_ps_slot;
        n_ps_cls        = r_ps_cls;
        n_ps_head       = r_ps_head;
        n_tslot         = r_tslot;
        n_add_slot      = r_add_slot;
        n_add_head      = r_add_head;
        n_add_ok        = r_add_ok;
        w_wr            = '0;
        w_rd            = '0;

        // Split point for the head block of an alloc
        rem        = LEN_W'(r_cur_len - r_size[LEN_W-1:0]);
        split_addr = ADDR_W'(r_cur_start + ADDR_W'(r_size));

        // Fitting class and first non-empty class at or below it
        fidx  = fit_class(r_size);
        found = 1'b0;
        sel   = '0;
        for (int i = 0; i < NCLS; i++) begin
            if (CLS_IDX_W'(i) <= fidx && !r_head[i][LINK_W-1]) begin
                found = 1'b1;
                sel   = CLS_IDX_W'(i);
            end
        end

        // First inactive region
        rfound = 1'b0;
        rsel   = '0;
        for (int r = NUM_REGIONS - 1; r >= 0; r--) begin
            if (!r_region_active[r]) begin
                rfound = 1'b1;
                rsel   = REG_W'(r);
            end
        end

        cls  = class_of(r_pl_len);
        rcls = class_of(rem);
        ccls = class_of(r_cur_len);
        ucnt = CNT_W'(w_rd_data.use_cnt - 1'b1);
        hd   = r_head[r_ps_cls];
        sz   = (SIZE_W'(i_req_size) + SIZE_W'(HEADER_BYTES + 2)) & ~SIZE_W'(1);

        unique case (r_state)
            // Sweep the descriptors after reset; region zero is one free block
            S_CLR: begin
                w_wr.en            = 1'b1;
                w_wr.addr          = r_clr;
                w_wr.mask          = '1;
                w_wr.mask.fprev    = (r_clr == '0);
                w_wr.mask.fnext    = (r_clr == '0);
                w_wr.data.len      = (r_clr == '0) ? LEN_W'(REGION_BYTES) : '0;
                w_wr.data.pprev    = LINK_NIL;
                w_wr.data.pnext    = LINK_NIL;
                w_wr.data.fprev    = LINK_NIL;
                w_wr.data.fnext    = LINK_NIL;
                n_clr              = SLOT_W'(r_clr + 1'b1);
                if (r_clr == SLOT_W'(NSLOTS - 1)) n_state = S_IDLE;
            end

            // Take a request; run a deferred region add first
            S_IDLE: begin
                if (start) begin
                    n_op     = i_op;
                    n_size   = (sz < SIZE_W'(MIN_BLOCK)) ? SIZE_W'(MIN_BLOCK) : sz;
                    n_rsv    = (RSV_W'(i_headroom) + 1'b1) & ~RSV_W'(1);
                    n_atomic = i_atomic;
                    n_handle = i_handle;
                    n_status = ST_OK;
                    n_baddr  = '0;
                    n_blen   = '0;
                    n_daddr  = '0;
                    if (r_grow) begin
                        n_grow  = 1'b0;
                        n_ret   = S_DISP;
                        n_state = S_ADD0;
                    end else begin
                        n_state = S_DISP;
                    end
                end
            end

            // Add a region as one free block at the head of class zero
            S_ADD0: begin
                if (!rfound) begin
                    n_add_ok = 1'b0;
                    n_state  = r_ret;
                end else begin
                    n_add_ok              = 1'b1;
                    n_grow                = 1'b0;
                    n_region_active[rsel] = 1'b1;
                    n_pool                = POOL_W'(r_pool + POOL_W'(REGION_BYTES));
                    w_wr.en               = 1'b1;
                    w_wr.addr             = SLOT_W'(rsel) << SPLIT_LEVELS;
                    w_wr.mask             = '1;
                    w_wr.data.len         = LEN_W'(REGION_BYTES);
                    w_wr.data.start       = ADDR_W'(rsel) << REGION_SHIFT;
                    w_wr.data.use_cnt     = '0;
                    w_wr.data.pprev       = LINK_NIL;
                    w_wr.data.pnext       = LINK_NIL;
                    w_wr.data.fprev       = LINK_NIL;
                    w_wr.data.fnext       = r_head[0];
                    n_head[0]             = LINK_W'(SLOT_W'(rsel) << SPLIT_LEVELS);
                    n_add_slot            = SLOT_W'(rsel) << SPLIT_LEVELS;
                    n_add_head            = r_head[0];
                    n_state               = r_head[0][LINK_W-1] ? r_ret : S_ADD1;
                end
            end

            S_ADD1: begin
                w_wr.en         = 1'b1;
                w_wr.addr       = r_add_head[SLOT_W-1:0];
                w_wr.mask.fprev = 1'b1;
                w_wr.data.fprev = LINK_W'(r_add_slot);
                n_state         = r_ret;
            end

            // Decode the request
            S_DISP: begin
                case (r_op) inside
                    OP_ALLOC: begin
                        if (r_size > SIZE_W'(REGION_BYTES)) begin
                            n_status = ST_TOO_LARGE;
                            if (r_failed != '1) n_failed = r_failed + 1'b1;
                            n_state  = S_FIN;
                        end else if (found) begin
                            n_cur     = r_head[sel][SLOT_W-1:0];
                            w_rd.en   = 1'b1;
                            w_rd.addr = r_head[sel][SLOT_W-1:0];
                            n_state   = S_AL_RD;
                        end else if (r_atomic) begin
                            n_grow   = 1'b1;
                            n_status = ST_EMPTY_ATOMIC;
                            if (r_failed != '1) n_failed = r_failed + 1'b1;
                            n_state  = S_FIN;
                        end else begin
                            n_ret   = S_AL_RETRY;
                            n_state = S_ADD0;
                        end
                    end
                    OP_REF, OP_DROP, OP_FREE: begin
                        n_cur     = r_handle[ADDR_W-1:MIN_SHIFT];
                        w_rd.en   = 1'b1;
                        w_rd.addr = r_handle[ADDR_W-1:MIN_SHIFT];
                        n_state   = S_H_RD;
                    end
                    OP_TICK: begin
                        n_state = S_TK0;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end

            S_AL_RETRY: begin
                if (!r_add_ok) begin
                    n_status = ST_NO_REGION;
                    if (r_failed != '1) n_failed = r_failed + 1'b1;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_DISP;
                end
            end

            // Hold the head block and unlink it
            S_AL_RD: begin
                n_cur_len   = w_rd_data.len;
                n_cur_start = w_rd_data.start;
                n_cur_pnext = w_rd_data.pnext;
                n_pl_len    = w_rd_data.len;
                n_pl_fprev  = w_rd_data.fprev;
                n_pl_fnext  = w_rd_data.fnext;
                n_ret       = S_AL_SPLIT;
                n_state     = S_PL0;
            end

            // Unlink a block from its free list
            S_PL0: begin
                if (r_pl_fprev[LINK_W-1]) begin
                    if (cls < CLS_W'(NCLS)) n_head[cls[CLS_IDX_W-1:0]] = r_pl_fnext;
                end else begin
                    w_wr.en         = 1'b1;
                    w_wr.addr       = r_pl_fprev[SLOT_W-1:0];
                    w_wr.mask.fnext = 1'b1;
                    w_wr.data.fnext = r_pl_fnext;
                end
                n_state = r_pl_fnext[LINK_W-1] ? r_ret : S_PL1;
            end

            S_PL1: begin
                w_wr.en         = 1'b1;
                w_wr.addr       = r_pl_fnext[SLOT_W-1:0];
                w_wr.mask.fprev = 1'b1;
                w_wr.data.fprev = r_pl_fprev;
                n_state         = r_ret;
            end

            // Split off the tail when it is big enough to stand alone
            S_AL_SPLIT: begin
                if (rem >= LEN_W'(MIN_BLOCK)) begin
                    n_tslot = split_addr[ADDR_W-1:MIN_SHIFT];
                    if (!r_cur_pnext[LINK_W-1]) begin
                        w_wr.en         = 1'b1;
                        w_wr.addr       = r_cur_pnext[SLOT_W-1:0];
                        w_wr.mask.pprev = 1'b1;
                        w_wr.data.pprev = LINK_W'(split_addr[ADDR_W-1:MIN_SHIFT]);
                    end
                    n_state = S_AL_T;
                end else begin
                    w_wr.en           = 1'b1;
                    w_wr.addr         = r_cur;
                    w_wr.mask.use_cnt = 1'b1;
                    w_wr.data.use_cnt = CNT_W'(1);
                    n_state           = S_AL_OUT;
                end
            end

            S_AL_T: begin
                w_wr.en           = 1'b1;
                w_wr.addr         = r_tslot;
                w_wr.mask.len     = 1'b1;
                w_wr.mask.start   = 1'b1;
                w_wr.mask.use_cnt = 1'b1;
                w_wr.mask.pprev   = 1'b1;
                w_wr.mask.pnext   = 1'b1;
                w_wr.data.len     = rem;
                w_wr.data.start   = split_addr;
                w_wr.data.use_cnt = '0;
                w_wr.data.pnext   = r_cur_pnext;
                w_wr.data.pprev   = LINK_W'(r_cur);
                n_state           = S_AL_S;
            end

            S_AL_S: begin
                w_wr.en           = 1'b1;
                w_wr.addr         = r_cur;
                w_wr.mask.len     = 1'b1;
                w_wr.mask.use_cnt = 1'b1;
                w_wr.mask.pnext   = 1'b1;
                w_wr.data.len     = r_size[LEN_W-1:0];
                w_wr.data.use_cnt = CNT_W'(1);
                w_wr.data.pnext   = LINK_W'(r_tslot);
                n_cur_len         = r_size[LEN_W-1:0];
                n_ps_slot         = r_tslot;
                n_ps_cls          = rcls[CLS_IDX_W-1:0];
                n_ret             = S_AL_OUT;
                n_state           = S_PS0;
            end

            // Push a block at the head of a free list
            S_PS0: begin
                w_wr.en            = 1'b1;
                w_wr.addr          = r_ps_slot;
                w_wr.mask.fprev    = 1'b1;
                w_wr.mask.fnext    = 1'b1;
                w_wr.data.fprev    = LINK_NIL;
                w_wr.data.fnext    = hd;
                n_head[r_ps_cls]   = LINK_W'(r_ps_slot);
                n_ps_head          = hd;
                n_state            = hd[LINK_W-1] ? r_ret : S_PS1;
            end

            S_PS1: begin
                w_wr.en         = 1'b1;
                w_wr.addr       = r_ps_head[SLOT_W-1:0];
                w_wr.mask.fprev = 1'b1;
                w_wr.data.fprev = LINK_W'(r_ps_slot);
                n_state         = r_ret;
            end

            S_AL_OUT: begin
                n_baddr = r_cur_start;
                n_blen  = r_cur_len;
                n_daddr = ADDR_W'(r_cur_start + ADDR_W'(HEADER_BYTES) + ADDR_W'(r_rsv));
                n_state = S_FIN;
            end

            // Check the handle, then count or release
            S_H_RD: begin
                n_cur_len   = w_rd_data.len;
                n_cur_start = w_rd_data.start;
                n_cur_pnext = w_rd_data.pnext;
                n_cur_pprev = w_rd_data.pprev;
                if (w_rd_data.len == '0 || w_rd_data.start != r_handle ||
                    w_rd_data.use_cnt == '0) begin
                    n_status = ST_CORRUPT;
                    n_state  = S_FIN;
                end else if (r_op == OP_REF) begin
                    if (w_rd_data.use_cnt != '1) begin
                        w_wr.en           = 1'b1;
                        w_wr.addr         = r_cur;
                        w_wr.mask.use_cnt = 1'b1;
                        w_wr.data.use_cnt = CNT_W'(w_rd_data.use_cnt + 1'b1);
                    end
                    n_state = S_FIN;
                end else if (r_op == OP_DROP) begin
                    w_wr.en           = 1'b1;
                    w_wr.addr         = r_cur;
                    w_wr.mask.use_cnt = 1'b1;
                    w_wr.data.use_cnt = ucnt;
                    n_state           = (ucnt == '0) ? S_REL0 : S_FIN;
                end else begin
                    n_state = S_REL0;
                end
            end

            // Merge with a free physical predecessor
            S_REL0: begin
                if (!r_cur_pprev[LINK_W-1]) begin
                    w_rd.en   = 1'b1;
                    w_rd.addr = r_cur_pprev[SLOT_W-1:0];
                    n_state   = S_REL1;
                end else begin
                    n_state = S_REL3;
                end
            end

            S_REL1: begin
                if (w_rd_data.use_cnt == '0) begin
                    n_nb       = r_cur_pprev[SLOT_W-1:0];
                    n_nb_len   = w_rd_data.len;
                    n_pl_len   = w_rd_data.len;
                    n_pl_fprev = w_rd_data.fprev;
                    n_pl_fnext = w_rd_data.fnext;
                    n_ret      = S_REL2;
                    n_state    = S_PL0;
                end else begin
                    n_state = S_REL3;
                end
            end

            S_REL2: begin
                w_wr.en           = 1'b1;
                w_wr.addr         = r_cur;
                w_wr.mask.len     = 1'b1;
                w_wr.mask.use_cnt = 1'b1;
                w_wr.data.len     = '0;
                w_wr.data.use_cnt = '0;
                n_state           = S_REL2A;
            end

            S_REL2A: begin
                w_wr.en         = 1'b1;
                w_wr.addr       = r_nb;
                w_wr.mask.len   = 1'b1;
                w_wr.mask.pnext = 1'b1;
                w_wr.data.len   = LEN_W'(r_nb_len + r_cur_len);
                w_wr.data.pnext = r_cur_pnext;
                n_cur           = r_nb;
                n_cur_len       = LEN_W'(r_nb_len + r_cur_len);
                n_state         = r_cur_pnext[LINK_W-1] ? S_REL3 : S_REL2B;
            end

            S_REL2B: begin
                w_wr.en         = 1'b1;
                w_wr.addr       = r_cur_pnext[SLOT_W-1:0];
                w_wr.mask.pprev = 1'b1;
                w_wr.data.pprev = LINK_W'(r_cur);
                n_state         = S_REL3;
            end

            // Merge with a free physical successor
            S_REL3: begin
                if (!r_cur_pnext[LINK_W-1]) begin
                    w_rd.en   = 1'b1;
                    w_rd.addr = r_cur_pnext[SLOT_W-1:0];
                    n_state   = S_REL4;
                end else begin
                    n_state = S_REL6;
                end
            end

            S_REL4: begin
                if (w_rd_data.use_cnt == '0) begin
                    n_nb       = r_cur_pnext[SLOT_W-1:0];
                    n_nb_len   = w_rd_data.len;
                    n_nb_pnext = w_rd_data.pnext;
                    n_pl_len   = w_rd_data.len;
                    n_pl_fprev = w_rd_data.fprev;
                    n_pl_fnext = w_rd_data.fnext;
                    n_ret      = S_REL5;
                    n_state    = S_PL0;
                end else begin
                    n_state = S_REL6;
                end
            end

            S_REL5: begin
                w_wr.en         = 1'b1;
                w_wr.addr       = r_cur;
                w_wr.mask.len   = 1'b1;
                w_wr.mask.pnext = 1'b1;
                w_wr.data.len   = LEN_W'(r_cur_len + r_nb_len);
                w_wr.data.pnext = r_nb_pnext;
                n_cur_len       = LEN_W'(r_cur_len + r_nb_len);
                n_cur_pnext     = r_nb_pnext;
                n_state         = r_nb_pnext[LINK_W-1] ? S_REL5C : S_REL5B;
            end

            S_REL5B: begin
                w_wr.en         = 1'b1;
                w_wr.addr       = r_nb_pnext[SLOT_W-1:0];
                w_wr.mask.pprev = 1'b1;
                w_wr.data.pprev = LINK_W'(r_cur);
                n_state         = S_REL5C;
            end

            S_REL5C: begin
                w_wr.en       = 1'b1;
                w_wr.addr     = r_nb;
                w_wr.mask.len = 1'b1;
                w_wr.data.len = '0;
                n_state       = S_REL6;
            end

            // List the merged block, or flag a length that fits no class
            S_REL6: begin
                if (ccls >= CLS_W'(NCLS)) begin
                    n_status = ST_CORRUPT;
                    n_state  = S_FIN;
                end else begin
                    w_wr.en           = 1'b1;
                    w_wr.addr         = r_cur;
                    w_wr.mask.use_cnt = 1'b1;
                    w_wr.data.use_cnt = '0;
                    n_ps_slot         = r_cur;
                    n_ps_cls          = ccls[CLS_IDX_W-1:0];
                    n_ret             = S_FIN;
                    n_state           = S_PS0;
                end
            end

            // Release whole free regions while more than one is listed
            S_TK0: begin
                if (r_head[0][LINK_W-1]) begin
                    n_state = S_FIN;
                end else begin
                    n_nb      = r_head[0][SLOT_W-1:0];
                    w_rd.en   = 1'b1;
                    w_rd.addr = r_head[0][SLOT_W-1:0];
                    n_state   = S_TK1;
                end
            end

            S_TK1: begin
                if (w_rd_data.fnext[LINK_W-1]) begin
                    n_state = S_FIN;
                end else begin
                    n_pl_len   = w_rd_data.len;
                    n_pl_fprev = w_rd_data.fprev;
                    n_pl_fnext = w_rd_data.fnext;
                    n_ret      = S_TK2;
                    n_state    = S_PL0;
                end
            end

            S_TK2: begin
                w_wr.en       = 1'b1;
                w_wr.addr     = r_nb;
                w_wr.mask.len = 1'b1;
                w_wr.data.len = '0;
                n_region_active[r_nb[SLOT_W-1 -: REG_W]] = 1'b0;
                n_pool        = POOL_W'(r_pool - POOL_W'(REGION_BYTES));
                n_state       = S_TK0;
            end

            // Present the result for one cycle
            S_FIN: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLR;
            r_clr           <= '0;
            r_valid         <= 1'b0;
            r_pool          <= POOL_W'(REGION_BYTES);
            r_failed        <= '0;
            r_grow          <= 1'b0;
            r_region_active <= NUM_REGIONS'(1);
            for (int i = 0; i < NCLS; i++) begin
                r_head[i] <= (i == 0) ? '0 : LINK_NIL;
            end
        end else begin
            r_state         <= n_state;
            r_clr           <= n_clr;
            r_valid         <= n_valid;
            r_pool          <= n_pool;
            r_failed        <= n_failed;
            r_grow          <= n_grow;
            r_region_active <= n_region_active;
            r_head          <= n_head;
        end
    end

    // Request and working values
    always_ff @(posedge i_clk) begin
        r_ret       <= n_ret;
        r_op        <= n_op;
        r_size      <= n_size;
        r_rsv       <= n_rsv;
        r_atomic    <= n_atomic;
        r_handle    <= n_handle;
        r_status    <= n_status;
        r_baddr     <= n_baddr;
        r_blen      <= n_blen;
        r_daddr     <= n_daddr;
        r_cur       <= n_cur;
        r_cur_len   <= n_cur_len;
        r_cur_start <= n_cur_start;
        r_cur_pnext <= n_cur_pnext;
        r_cur_pprev <= n_cur_pprev;
        r_nb        <= n_nb;
        r_nb_len    <= n_nb_len;
        r_nb_pnext  <= n_nb_pnext;
        r_pl_len    <= n_pl_len;
        r_pl_fprev  <= n_pl_fprev;
        r_pl_fnext  <= n_pl_fnext;
        r_ps_slot   <= n_ps_slot;
        r_ps_cls    <= n_ps_cls;
        r_ps_head   <= n_ps_head;
        r_tslot     <= n_tslot;
        r_add_slot  <= n_add_slot;
        r_add_head  <= n_add_head;
        r_add_ok    <= n_add_ok;
    end

    assign busy                 = (r_state != S_IDLE);
    assign o_valid              = r_valid;
    assign o_status             = r_status;
    assign o_block_addr         = r_baddr;
    assign o_block_len          = r_blen;
    assign o_data_addr          = r_daddr;
    assign o_pool_bytes         = r_pool;
    assign o_failed_allocations = r_failed;

`ifndef NO_ASSERTIONS
    // A result shows only as the sequencer returns to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_IDLE))
        else $error("result strobe outside idle");

    // Reads and writes of the descriptor memory never share a cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr.en && w_rd.en))
        else $error("descriptor read and write in one cycle");

    // Pool byte count tracks the active regions
    a_pool_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool == (POOL_W'($countones(r_region_active)) << REGION_SHIFT))
        else $error("pool bytes disagree with active regions");

    // The failure counter never moves backward
    a_fail_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_failed >= $past(r_failed))
        else $error("failure counter decreased");

    // A taken request turns the block busy with no result showing yet
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("request taken without going busy");
`endif

endmodule

/* tb/sba_checker.sv */
// Result checker for the segregated buffer allocator: predicts every request and
// compares each result strobe with the oldest prediction. Depends on sba_pkg.
`timescale 1ns / 1ps

module sba_checker import sba_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [sba_pkg::OP_W-1:0]     i_op,
    input  logic [15:0]                  i_req_size,
    input  logic [14:0]                  i_headroom,
    input  logic                         i_atomic,
    input  logic [sba_pkg::ADDR_W-1:0]   i_handle,
    input  logic                         o_valid,
    input  logic [sba_pkg::ST_W-1:0]     o_status,
    input  logic [sba_pkg::ADDR_W-1:0]   o_block_addr,
    input  logic [sba_pkg::LEN_W-1:0]    o_block_len,
    input  logic [sba_pkg::ADDR_W-1:0]   o_data_addr,
    input  logic [sba_pkg::POOL_W-1:0]   o_pool_bytes,
    input  logic [sba_pkg::FAIL_W-1:0]   o_failed_allocations,
    output int                           o_errors,
    output int                           o_pending,
    output int                           o_results
);

    localparam logic [15:0] NO_SLOT = 16'hFFFF;

    typedef struct {
        logic [sba_pkg::ST_W-1:0]   status;
        logic [sba_pkg::ADDR_W-1:0] baddr;
        logic [sba_pkg::LEN_W-1:0]  blen;
        logic [sba_pkg::ADDR_W-1:0] daddr;
        logic [sba_pkg::POOL_W-1:0] pool;
        logic [sba_pkg::FAIL_W-1:0] fails;
    } t_outcome;

    // Shadow pool state
    int unsigned blk_len   [NSLOTS];
    int unsigned blk_base  [NSLOTS];
    logic [15:0] refs      [NSLOTS];
    logic [15:0] phys_prev [NSLOTS];
    logic [15:0] phys_next [NSLOTS];
    logic [15:0] list_prev [NSLOTS];
    logic [15:0] list_next [NSLOTS];
    logic [15:0] class_head[NCLS];
    bit          region_on [NUM_REGIONS];
    int unsigned bytes_held;
    int unsigned fail_total;
    bit          grow_later;

    t_outcome outcome_q[$];
    int       mismatches;

    function automatic int unsigned size_class(int unsigned len);
        if (len > REGION_BYTES) return NCLS;
        for (int i = 0; i < NCLS; i++)
            if (len >= (REGION_BYTES >> i)) return i;
        return NCLS;
    endfunction

    function automatic void list_insert(int unsigned s, int unsigned c);
        logic [15:0] h;
        h = class_head[c];
        list_next[s] = h;
        list_prev[s] = NO_SLOT;
        if (h != NO_SLOT) list_prev[h] = 16'(s);
        class_head[c] = 16'(s);
    endfunction

    function automatic void list_unlink(int unsigned s);
        int unsigned c;
        logic [15:0] p, n;
        c = size_class(blk_len[s]);
        p = list_prev[s];
        n = list_next[s];
        if (p == NO_SLOT) begin
            if (c < NCLS) class_head[c] = n;
        end else begin
            list_next[p] = n;
        end
        if (n != NO_SLOT) list_prev[n] = p;
    endfunction

    function automatic bit grow_pool();
        int unsigned r, s;
        for (r = 0; r < NUM_REGIONS; r++)
            if (!region_on[r]) break;
        if (r >= NUM_REGIONS) return 0;
        region_on[r] = 1;
        s = r << SPLIT_LEVELS;
        blk_base[s] = r * REGION_BYTES;
        blk_len[s] = REGION_BYTES;
        refs[s] = 0;
        phys_prev[s] = NO_SLOT;
        phys_next[s] = NO_SLOT;
        list_insert(s, 0);
        bytes_held += REGION_BYTES;
        grow_later = 0;
        return 1;
    endfunction

    function automatic void note_failure();
        if (fail_total != 32'hFFFF_FFFF) fail_total++;
    endfunction

    // Merge a released block with free neighbours and list it
    function automatic logic [2:0] give_back(int unsigned cur);
        logic [15:0] p, n, nn;
        int unsigned c;
        p = phys_prev[cur];
        if (p != NO_SLOT && refs[p] == 0) begin
            list_unlink(p);
            n = phys_next[cur];
            phys_next[p] = n;
            if (n != NO_SLOT) phys_prev[n] = p;
            blk_len[p] += blk_len[cur];
            blk_len[cur] = 0;
            refs[cur] = 0;
            cur = p;
        end
        n = phys_next[cur];
        if (n != NO_SLOT && refs[n] == 0) begin
            nn = phys_next[n];
            list_unlink(n);
            phys_next[cur] = nn;
            if (nn != NO_SLOT) phys_prev[nn] = 16'(cur);
            blk_len[cur] += blk_len[n];
            blk_len[n] = 0;
        end
        c = size_class(blk_len[cur]);
        if (c >= NCLS) return sba_pkg::ST_CORRUPT;
        refs[cur] = 0;
        list_insert(cur, c);
        return sba_pkg::ST_OK;
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i < NSLOTS; i++) begin
            blk_len[i] = 0;
            blk_base[i] = 0;
            refs[i] = 0;
            phys_prev[i] = NO_SLOT;
            phys_next[i] = NO_SLOT;
            list_prev[i] = 0;
            list_next[i] = 0;
        end
        for (int i = 0; i < NCLS; i++) class_head[i] = NO_SLOT;
        for (int i = 0; i < NUM_REGIONS; i++) region_on[i] = 0;
        bytes_held = 0;
        fail_total = 0;
        grow_later = 0;
        void'(grow_pool());
    endfunction

    // Apply one request to the shadow pool and return the result it gives
    function automatic t_outcome serve_request(logic [2:0] op, logic [15:0] req,
                                               logic [14:0] hr, logic at,
                                               logic [16:0] h);
        t_outcome o;
        int unsigned size, rsv, s, t, a, r;
        int idx, i;
        logic [15:0] nx, hd;
        o = '{default: '0};
        if (grow_later) begin
            grow_later = 0;
            void'(grow_pool());
        end
        if (op == sba_pkg::OP_ALLOC) begin
            size = (req + HEADER_BYTES + 2) & ~32'd1;
            rsv = (hr + 1) & ~32'd1;
            if (size < MIN_BLOCK) size = MIN_BLOCK;
            if (size > REGION_BYTES) begin
                o.status = sba_pkg::ST_TOO_LARGE;
                note_failure();
            end else begin
                idx = SPLIT_LEVELS;
                while (idx > 0 && size > (REGION_BYTES >> idx)) idx--;
                forever begin
                    for (i = idx; i >= 0 && class_head[i] == NO_SLOT; i--) ;
                    if (i >= 0) break;
                    if (at) begin
                        grow_later = 1;
                        o.status = sba_pkg::ST_EMPTY_ATOMIC;
                        break;
                    end
                    if (!grow_pool()) begin
                        o.status = sba_pkg::ST_NO_REGION;
                        break;
                    end
                end
                if (o.status != sba_pkg::ST_OK) begin
                    note_failure();
                end else begin
                    s = class_head[i];
                    list_unlink(s);
                    if (blk_len[s] - size >= MIN_BLOCK) begin
                        a = blk_base[s] + size;
                        t = a / MIN_BLOCK;
                        nx = phys_next[s];
                        if (t < NSLOTS) begin
                            if (nx != NO_SLOT) phys_prev[nx] = 16'(t);
                            blk_base[t] = a;
                            blk_len[t] = blk_len[s] - size;
                            refs[t] = 0;
                            phys_next[t] = nx;
                            phys_prev[t] = 16'(s);
                            phys_next[s] = 16'(t);
                            blk_len[s] = size;
                            list_insert(t, size_class(blk_len[t]));
                        end
                    end
                    refs[s] = 1;
                    o.baddr = 17'(blk_base[s]);
                    o.blen = 16'(blk_len[s]);
                    o.daddr = 17'(blk_base[s] + HEADER_BYTES + rsv);
                end
            end
        end else if (op == sba_pkg::OP_REF || op == sba_pkg::OP_DROP ||
                     op == sba_pkg::OP_FREE) begin
            s = h / MIN_BLOCK;
            if (s >= NSLOTS || blk_len[s] == 0 || blk_base[s] != h || refs[s] == 0) begin
                o.status = sba_pkg::ST_CORRUPT;
            end else if (op == sba_pkg::OP_REF) begin
                if (refs[s] != 16'hFFFF) refs[s]++;
            end else if (op == sba_pkg::OP_DROP) begin
                refs[s]--;
                if (refs[s] == 0) o.status = give_back(s);
            end else begin
                o.status = give_back(s);
            end
        end else if (op == sba_pkg::OP_TICK) begin
            // Release whole free regions while more than one is listed
            forever begin
                hd = class_head[0];
                if (hd == NO_SLOT || list_next[hd] == NO_SLOT) break;
                list_unlink(hd);
                blk_len[hd] = 0;
                r = hd >> SPLIT_LEVELS;
                if (r < NUM_REGIONS) region_on[r] = 0;
                bytes_held -= REGION_BYTES;
            end
        end
        o.pool = 18'(bytes_held);
        o.fails = fail_total;
        return o;
    endfunction

    initial begin
        pool_reset();
        mismatches = 0;
        o_results = 0;
    end

    assign o_errors  = mismatches;
    assign o_pending = outcome_q.size();

    // Compare the result of this edge first, then predict the request taken at it
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n) begin
            if (o_valid) begin
                o_results <= o_results + 1;
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result at %0t, status %0d", $realtime,
                                 o_status);
                end else begin
                    e = outcome_q.pop_front();
                    if (e.status !== o_status || e.baddr !== o_block_addr ||
                        e.blen !== o_block_len || e.daddr !== o_data_addr ||
                        e.pool !== o_pool_bytes || e.fails !== o_failed_allocations) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR at %0t: expected st %0d blk %0d len %0d data %0d",
                                      " pool %0d fail %0d, got st %0d blk %0d len %0d",
                                      " data %0d pool %0d fail %0d"},
                                     $realtime, e.status, e.baddr, e.blen, e.daddr, e.pool,
                                     e.fails, o_status, o_block_addr, o_block_len,
                                     o_data_addr, o_pool_bytes, o_failed_allocations);
                    end
                end
            end
            if (start && !busy)
                outcome_q.push_back(serve_request(i_op, i_req_size, i_headroom,
                                                  i_atomic, i_handle));
        end
    end

endmodule

/* tb/testbench.sv */
// Top of the allocator testbench: clock, reset, request stimulus and verdict.
// Depends on sba_pkg, sba_checker and segregated_buffer_allocator_top.
`timescale 1ns / 1ps

module testbench import sba_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int REF_REPEATS    = 8;

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                start = 0;
    logic                busy;
    logic [OP_W-1:0]     i_op = OP_TICK;
    logic [15:0]         i_req_size = 0;
    logic [14:0]         i_headroom = 0;
    logic                i_atomic = 0;
    logic [ADDR_W-1:0]   i_handle = 0;
    logic                o_valid;
    logic [ST_W-1:0]     o_status;
    logic [ADDR_W-1:0]   o_block_addr;
    logic [LEN_W-1:0]    o_block_len;
    logic [ADDR_W-1:0]   o_data_addr;
    logic [POOL_W-1:0]   o_pool_bytes;
    logic [FAIL_W-1:0]   o_failed_allocations;

    int errors, pending, results;
    int idle_pct;
    int quiet_cycles = 0;
    int requests_sent = 0;

    // Handles the stimulus may still use, with their reference counts
    logic [ADDR_W-1:0] live_addr[$];
    int                live_refs[$];
    logic [OP_W-1:0]   op_log[$];
    bit                track_live = 0;
    logic [ADDR_W-1:0] last_grant = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    segregated_buffer_allocator_top dut (.*);

    sba_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_op, .i_req_size, .i_headroom, .i_atomic,
        .i_handle, .o_valid, .o_status, .o_block_addr, .o_block_len, .o_data_addr,
        .o_pool_bytes, .o_failed_allocations,
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Learn granted blocks from the result stream
    always @(posedge i_clk) begin
        logic [OP_W-1:0] op;
        if (i_rst_n && o_valid && op_log.size() > 0) begin
            op = op_log.pop_front();
            if (op == OP_ALLOC && o_status == ST_OK) begin
                last_grant = o_block_addr;
                if (track_live) begin
                    live_addr.push_back(o_block_addr);
                    live_refs.push_back(1);
                end
            end
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Drive one request at a falling edge and hold it until the transfer
    task automatic issue(logic [OP_W-1:0] op, logic [15:0] req, logic [14:0] hr,
                         logic at, logic [ADDR_W-1:0] h);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 0;
            @(negedge i_clk);
        end
        start <= 1;
        i_op <= op;
        i_req_size <= req;
        i_headroom <= hr;
        i_atomic <= at;
        i_handle <= h;
        do @(posedge i_clk); while (busy);
        op_log.push_back(op);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Hold off new requests until every result is back
    task automatic drain();
        start <= 0;
        @(negedge i_clk);
        while (pending != 0 || op_log.size() != 0) @(negedge i_clk);
    endtask

    task automatic random_request();
        int pick, k;
        logic [15:0] req;
        pick = $urandom_range(99, 0);
        if (pick < 40 || live_addr.size() == 0) begin
            if ($urandom_range(9, 0) == 0) req = 16'($urandom());
            else req = 16'($urandom_range(3000, 0));
            issue(OP_ALLOC, req, 15'($urandom()), $urandom_range(4, 0) == 0, 17'($urandom()));
        end else if (pick < 85) begin
            k = $urandom_range(live_addr.size() - 1, 0);
            case ($urandom_range(2, 0))
                0: begin
                    live_refs[k]++;
                    issue(OP_REF, 16'($urandom()), 15'($urandom()), 1'($urandom()),
                          live_addr[k]);
                end
                1: begin
                    issue(OP_DROP, 16'($urandom()), 15'($urandom()), 1'($urandom()),
                          live_addr[k]);
                    live_refs[k]--;
                    if (live_refs[k] == 0) begin
                        live_addr.delete(k);
                        live_refs.delete(k);
                    end
                end
                default: begin
                    issue(OP_FREE, 16'($urandom()), 15'($urandom()), 1'($urandom()),
                          live_addr[k]);
                    live_addr.delete(k);
                    live_refs.delete(k);
                end
            endcase
        end else if (pick < 91) begin
            // Stale or random handle
            issue(OP_ALLOC + 3'($urandom_range(3, 1)), 16'($urandom()), 15'($urandom()),
                  1'($urandom()), 17'($urandom()));
        end else if (pick < 97) begin
            issue(OP_TICK, 16'($urandom()), 15'($urandom()), 1'($urandom()),
                  17'($urandom()));
        end else begin
            issue(3'($urandom_range(7, 5)), 16'($urandom()), 15'($urandom()),
                  1'($urandom()), 17'($urandom()));
        end
    endtask

    initial begin
        idle_pct = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: edges of sizes, atomic deferral, running out of regions
        issue(OP_ALLOC, 16'd0, 15'd0, 1'b0, 17'd0);
        issue(OP_ALLOC, 16'hFFFF, 15'h7FFF, 1'b1, 17'h1FFFF);
        issue(OP_ALLOC, 16'd32704, 15'd1, 1'b0, 17'd0);
        issue(OP_ALLOC, 16'd32702, 15'h7FFF, 1'b0, 17'd0);
        issue(OP_ALLOC, 16'd32702, 15'd3, 1'b1, 17'd0);
        issue(OP_TICK, 16'd0, 15'd0, 1'b0, 17'd0);
        issue(OP_ALLOC, 16'd32702, 15'd0, 1'b0, 17'd0);
        issue(OP_ALLOC, 16'd32702, 15'd0, 1'b0, 17'd0);
        issue(OP_ALLOC, 16'd32702, 15'd0, 1'b0, 17'd0);
        issue(OP_ALLOC, 16'd100, 15'd0, 1'b1, 17'd0);
        issue(OP_REF, 16'd0, 15'd0, 1'b0, 17'd0);
        issue(OP_DROP, 16'd0, 15'd0, 1'b0, 17'd0);
        issue(OP_DROP, 16'd0, 15'd0, 1'b0, 17'd0);
        issue(OP_DROP, 16'd0, 15'd0, 1'b0, 17'd0);
        issue(OP_FREE, 16'd0, 15'd0, 1'b0, 17'd32768);
        issue(OP_FREE, 16'd0, 15'd0, 1'b0, 17'd65536);
        issue(OP_DROP, 16'd0, 15'd0, 1'b0, 17'd98304);
        issue(OP_REF, 16'd0, 15'd0, 1'b0, 17'h1FFFF);
        issue(3'd5, 16'd0, 15'd0, 1'b0, 17'd0);
        issue(3'd6, 16'd0, 15'd0, 1'b0, 17'd0);
        issue(3'd7, 16'hFFFF, 15'h7FFF, 1'b1, 17'h1FFFF);
        issue(OP_TICK, 16'd0, 15'd0, 1'b0, 17'd0);

        // Stack several references on one block, then drop one
        issue(OP_ALLOC, 16'd500, 15'd7, 1'b0, 17'd0);
        drain();
        for (int i = 0; i < REF_REPEATS; i++)
            issue(OP_REF, 16'd0, 15'd0, 1'b0, last_grant);
        issue(OP_DROP, 16'd0, 15'd0, 1'b0, last_grant);
        drain();

        // Random traffic over four idling phases
        track_live = 1;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1: idle_pct = 46;
                3: idle_pct = 27;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) random_request();
            drain();
        end

        idle_pct = 0;
        start <= 0;
        repeat (50) @(posedge i_clk);
        $display("Covered %0d requests and %0d results: size edges, atomic deferral,",
                 requests_sent, results);
        $display("region exhaustion, repeated references, merges, ticks, bad handles.");
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
